>>> hw/rtl/tdpt_pkg.sv
// Shared types for the trial division prime test block.
package tdpt_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } state_e;

  // Status from the serial divider to the control FSM.
  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_stat_t;

endpackage

>>> hw/rtl/tdpt_div_serial.sv
// Radix-2 restoring divider, one quotient bit per cycle, narrow remainder path.
module tdpt_div_serial #(
  parameter int WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [WIDTH-2:0]                  dividend_i,
  input  logic [WIDTH/2:0]                  divisor_i,
  output logic [WIDTH-2:0]                  quotient_o,
  output tdpt_pkg::div_stat_t               stat_o
);

  localparam int N  = WIDTH - 1;
  localparam int DW = WIDTH / 2 + 1;
  localparam int CW = $clog2(N);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [N-1:0]  dvd_q, dvd_d;
  logic [N-1:0]  quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] dsr_q, dsr_d;

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic          last;

  // remainder stays below the divisor, so DW+1 bits cover the shifted trial value
  assign trial = {rem_q, dvd_q[N-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = trial >= {1'b0, dsr_q};
  assign last  = cnt_q == CW'(N - 1);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      quo_d  = '0;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      dvd_d = {dvd_q[N-2:0], 1'b0};
      quo_d = {quo_q[N-2:0], ge};
      rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
      cnt_d = cnt_q + CW'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign quotient_o      = quo_q;
  assign stat_o.done     = done_q;
  assign stat_o.rem_zero = rem_q == '0;

  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_last_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && last) |=> (done_q && !busy_q))
    else $error("divider did not finish after last step");

  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < dsr_q))
    else $error("remainder not below divisor");

endmodule

>>> hw/rtl/trial_division_prime_test.sv
// Values below 2, negative ones included, are reported not prime without running the divider.
// Divisors are 2 then odd values, up to the first divisor above floor(sqrt(n)), or the first factor.
// Each divisor runs the bit-serial divider over all WIDTH-1 quotient bits, then a decision.
// One word in flight; a new word is taken as soon as the result is parked in the output register.
// Reset: rst_ni asynchronous, active low; clears FSM, divider control and output valid.
module trial_division_prime_test #(
  parameter int WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [WIDTH-1:0] number_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    is_prime_o
);

  localparam int N  = WIDTH - 1;
  localparam int DW = WIDTH / 2 + 1;

  tdpt_pkg::state_e    state_q, state_d;
  logic [N-1:0]        v_q, v_d;
  logic [DW-1:0]       d_q, d_d;
  logic                res_q, res_d;
  logic                out_valid_q, out_valid_d;
  logic                is_prime_q, is_prime_d;
  logic                div_start;
  logic [N-1:0]        div_quo;
  tdpt_pkg::div_stat_t div_stat;

  tdpt_div_serial #(
    .WIDTH(WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (v_d),
    .divisor_i  (d_d),
    .quotient_o (div_quo),
    .stat_o     (div_stat)
  );

  assign in_stall_o = state_q != tdpt_pkg::ST_IDLE;

  always_comb begin
    state_d     = state_q;
    v_d         = v_q;
    d_d         = d_q;
    res_d       = res_q;
    div_start   = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    is_prime_d  = is_prime_q;
    case (state_q)
      tdpt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          v_d = number_i[N-1:0];
          d_d = DW'(2);
          if (number_i[WIDTH-1] || (number_i[N-1:0] <= N'(1))) begin
            res_d   = 1'b0;
            state_d = tdpt_pkg::ST_OUT;
          end else begin
            div_start = 1'b1;
            state_d   = tdpt_pkg::ST_RUN;
          end
        end
      end
      tdpt_pkg::ST_RUN: begin
        if (div_stat.done) begin
          // d > n/d means d*d > n: no factor left to try
          if (N'(d_q) > div_quo) begin
            res_d   = 1'b1;
            state_d = tdpt_pkg::ST_OUT;
          end else if (div_stat.rem_zero) begin
            res_d   = 1'b0;
            state_d = tdpt_pkg::ST_OUT;
          end else begin
            d_d       = (d_q == DW'(2)) ? DW'(3) : d_q + DW'(2);
            div_start = 1'b1;
          end
        end
      end
      tdpt_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          is_prime_d  = res_q;
          state_d     = tdpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tdpt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tdpt_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q        <= v_d;
    d_q        <= d_d;
    res_q      <= res_d;
    is_prime_q <= is_prime_d;
  end

  assign out_valid_o = out_valid_q;
  assign is_prime_o  = is_prime_q;

  a_div_floor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tdpt_pkg::ST_RUN) |-> (d_q >= DW'(2)))
    else $error("trial divisor below two");

  a_done_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |=> !div_stat.done)
    else $error("divider done held longer than one cycle");

  a_done_in_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == tdpt_pkg::ST_RUN))
    else $error("divider finished outside of run state");

endmodule
